// ----- src/ilt_pkg.sv -----
// ----------------------------------------------------------------------------
// ilt_pkg
// Shared types and codes for the INI line tokenizer: parser states, character
// classes, line kinds, line status codes and the beats between the stages.
// ----------------------------------------------------------------------------
package ilt_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int OUTQ_DEPTH  = 2;
   localparam int OUTQ_AW     = $clog2(OUTQ_DEPTH);

   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LC_T   = 8'h74;
   localparam logic [7:0] CH_LC_R   = 8'h72;
   localparam logic [7:0] CH_LC_N   = 8'h6E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_EOL  = 1'b1;

   localparam logic [2:0] CL_DROP    = 3'd0;
   localparam logic [2:0] CL_NAME    = 3'd1;
   localparam logic [2:0] CL_SECT    = 3'd2;
   localparam logic [2:0] CL_VALUE   = 3'd3;
   localparam logic [2:0] CL_TENT    = 3'd4;
   localparam logic [2:0] CL_COMMENT = 3'd5;
   localparam logic [2:0] CL_END     = 3'd6;

   localparam logic [1:0] KIND_BLANK   = 2'd0;
   localparam logic [1:0] KIND_KEY     = 2'd1;
   localparam logic [1:0] KIND_SECTION = 2'd2;

   localparam logic [2:0] ER_OK      = 3'd0;
   localparam logic [2:0] ER_NAME    = 3'd1;
   localparam logic [2:0] ER_MISSING = 3'd2;
   localparam logic [2:0] ER_QUOTING = 3'd3;
   localparam logic [2:0] ER_SECTION = 3'd4;
   localparam logic [2:0] ER_SYNTAX  = 3'd5;

   typedef enum logic [3:0] {
      ST_WS1     = 4'd0,
      ST_NAME    = 4'd1,
      ST_WS2     = 4'd2,
      ST_WS3     = 4'd3,
      ST_VALUE   = 4'd4,
      ST_WS4     = 4'd5,
      ST_QUOTE   = 4'd6,
      ST_QESC    = 4'd7,
      ST_WS5     = 4'd8,
      ST_WS6     = 4'd9,
      ST_SECT    = 4'd10,
      ST_WS7     = 4'd11,
      ST_COMMENT = 4'd12,
      ST_INVALID = 4'd13
   } state_type;

   typedef struct packed {
      logic       eol;
      logic [7:0] code;
      logic [7:0] esc_code;
      logic       is_ws;
      logic       is_key;
      logic       is_lbrack;
      logic       is_rbrack;
      logic       is_hash;
      logic       is_eq;
      logic       is_dot;
      logic       is_bslash;
      logic       is_dquote;
      logic       is_squote;
   } token_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic [2:0] char_class;
      logic [1:0] line_kind;
      logic [2:0] line_status;
      logic       line_done;
   } result_type;

endpackage

// ----- src/ilt_front.sv -----
// ----------------------------------------------------------------------------
// ilt_front
// Input classifier: tags each incoming byte (whitespace, key character,
// punctuation) and precomputes the escape translation.
// ----------------------------------------------------------------------------
module ilt_front (
   input  logic               opcode,
   input  logic [7:0]         char_code,
   output ilt_pkg::token_type token
);
   import ilt_pkg::*;

   always_comb begin
      token.eol       = (opcode == OP_EOL);
      token.code      = char_code;
      token.is_ws     = (char_code == CH_SPACE) ||
                        ((char_code >= CH_TAB) && (char_code <= CH_CR));
      token.is_key    = ((char_code >= 8'h30) && (char_code <= 8'h39)) ||
                        ((char_code >= 8'h41) && (char_code <= 8'h5A)) ||
                        ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
                        (char_code == CH_UNDER);
      token.is_lbrack = (char_code == CH_LBRACK);
      token.is_rbrack = (char_code == CH_RBRACK);
      token.is_hash   = (char_code == CH_HASH);
      token.is_eq     = (char_code == CH_EQ);
      token.is_dot    = (char_code == CH_DOT);
      token.is_bslash = (char_code == CH_BSLASH);
      token.is_dquote = (char_code == CH_DQUOTE);
      token.is_squote = (char_code == CH_SQUOTE);
      case (char_code)
         CH_LC_T: token.esc_code = CH_TAB;
         CH_LC_R: token.esc_code = CH_CR;
         CH_LC_N: token.esc_code = CH_LF;
         default: token.esc_code = char_code;
      endcase
   end

endmodule

// ----- src/ilt_queue.sv -----
// ----------------------------------------------------------------------------
// ilt_queue
// Short token queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module ilt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  ilt_pkg::token_type wr_token,
   output logic               full,
   input  logic               rd_en,
   output ilt_pkg::token_type rd_token,
   output logic               not_empty
);
   import ilt_pkg::*;

   token_type             mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_wr, do_rd;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_wr     = wr_en && !full;
   assign do_rd     = rd_en && not_empty;
   assign rd_token  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_token;
      end
   end

endmodule

// ----- src/ilt_back.sv -----
// ----------------------------------------------------------------------------
// ilt_back
// Line parser: runs the fourteen-state machine on one token per cycle, while
// its two-entry output buffer has room, and places results in that buffer.
// ----------------------------------------------------------------------------
module ilt_back (
   input  logic                clock,
   input  logic                reset,
   input  ilt_pkg::token_type  tok,
   input  logic                tok_valid,
   output logic                tok_take,
   output ilt_pkg::result_type rsp,
   output logic                empty,
   input  logic                pop
);
   import ilt_pkg::*;

   state_type            state_ff, state_in;
   logic                 quote_single_ff, quote_single_in;
   logic [2:0]           error_ff, error_in;
   logic [1:0]           kind_ff, kind_in;
   logic                 go_err;
   logic [2:0]           err_code;
   logic [2:0]           cls;
   logic [7:0]           ch;
   logic [2:0]           eol_status;
   result_type           res;

   result_type           outq [OUTQ_DEPTH];
   logic [OUTQ_AW-1:0]   owr_ff, owr_in, ord_ff, ord_in;
   logic [OUTQ_AW:0]     ocount_ff, ocount_in;
   logic                 do_pop;

   assign empty    = (ocount_ff == '0);
   assign do_pop   = pop && !empty;
   assign tok_take = tok_valid &&
                     ((ocount_ff != (OUTQ_AW+1)'(OUTQ_DEPTH)) || do_pop);
   assign rsp      = outq[ord_ff];

   always_comb begin
      state_in        = state_ff;
      quote_single_in = quote_single_ff;
      kind_in         = kind_ff;
      go_err          = 1'b0;
      err_code        = ER_OK;
      cls             = CL_DROP;
      ch              = tok.code;
      unique case (state_ff)
         ST_WS1: begin
            if (tok.is_ws) begin
            end else if (tok.is_lbrack) begin
               state_in = ST_WS6;
            end else if (tok.is_key) begin
               cls = CL_NAME; kind_in = KIND_KEY; state_in = ST_NAME;
            end else if (tok.is_hash) begin
               state_in = ST_COMMENT;
            end else begin
               go_err = 1'b1; err_code = ER_NAME;
            end
         end
         ST_NAME: begin
            if (tok.is_key) cls = CL_NAME;
            else if (tok.is_ws) state_in = ST_WS2;
            else if (tok.is_eq) state_in = ST_WS3;
            else begin
               go_err = 1'b1; err_code = ER_NAME;
            end
         end
         ST_WS2: begin
            if (tok.is_ws) begin
            end else if (tok.is_eq) begin
               state_in = ST_WS3;
            end else begin
               go_err = 1'b1; err_code = ER_NAME;
            end
         end
         ST_WS3: begin
            if (tok.is_ws) begin
            end else if (tok.is_dquote || tok.is_squote) begin
               quote_single_in = tok.is_squote;
               state_in        = ST_QUOTE;
            end else begin
               cls = CL_VALUE; state_in = ST_VALUE;
            end
         end
         ST_VALUE: begin
            if (tok.is_ws) begin
               cls = CL_TENT; state_in = ST_WS4;
            end else begin
               cls = CL_VALUE;
            end
         end
         ST_WS4: begin
            if (tok.is_ws) cls = CL_TENT;
            else if (tok.is_hash) state_in = ST_COMMENT;
            else begin
               cls = CL_VALUE; state_in = ST_VALUE;
            end
         end
         ST_QUOTE: begin
            if (quote_single_ff ? tok.is_squote : tok.is_dquote) state_in = ST_WS5;
            else if (tok.is_bslash) state_in = ST_QESC;
            else cls = CL_VALUE;
         end
         ST_QESC: begin
            ch = tok.esc_code; cls = CL_VALUE; state_in = ST_QUOTE;
         end
         ST_WS5: begin
            if (tok.is_ws) begin
            end else if (tok.is_hash) begin
               state_in = ST_COMMENT;
            end else begin
               go_err = 1'b1; err_code = ER_SYNTAX;
            end
         end
         ST_WS6: begin
            if (tok.is_ws) begin
            end else if (tok.is_key) begin
               cls = CL_SECT; kind_in = KIND_SECTION; state_in = ST_SECT;
            end else begin
               go_err = 1'b1; err_code = ER_SECTION;
            end
         end
         ST_SECT: begin
            if (tok.is_key || tok.is_dot) cls = CL_SECT;
            else if (tok.is_rbrack) state_in = ST_WS5;
            else if (tok.is_ws) state_in = ST_WS7;
            else begin
               go_err = 1'b1; err_code = ER_SECTION;
            end
         end
         ST_WS7: begin
            if (tok.is_ws) begin
            end else if (tok.is_rbrack) begin
               state_in = ST_WS5;
            end else begin
               go_err = 1'b1; err_code = ER_SECTION;
            end
         end
         ST_COMMENT: begin
            cls = CL_COMMENT;
         end
         default: begin
            state_in = ST_INVALID;
         end
      endcase

      error_in = error_ff;
      if (go_err) begin
         state_in = ST_INVALID;
         if (error_ff == ER_OK) error_in = err_code;
      end

      eol_status = error_ff;
      if (error_ff == ER_OK) begin
         case (state_ff)
            ST_NAME, ST_WS2:          eol_status = ER_MISSING;
            ST_QUOTE, ST_QESC:        eol_status = ER_QUOTING;
            ST_WS6, ST_SECT, ST_WS7:  eol_status = ER_SYNTAX;
            default:                  eol_status = ER_OK;
         endcase
      end

      if (tok.eol) begin
         res.char_out    = '0;
         res.char_class  = CL_END;
         res.line_kind   = kind_ff;
         res.line_status = eol_status;
         res.line_done   = 1'b1;
         state_in        = ST_WS1;
         quote_single_in = 1'b0;
         error_in        = ER_OK;
         kind_in         = KIND_BLANK;
      end else begin
         res.char_out    = (cls == CL_DROP) ? 8'h00 : ch;
         res.char_class  = cls;
         res.line_kind   = KIND_BLANK;
         res.line_status = ER_OK;
         res.line_done   = 1'b0;
      end
   end

   always_comb begin
      owr_in    = tok_take ? owr_ff + 1'b1 : owr_ff;
      ord_in    = do_pop ? ord_ff + 1'b1 : ord_ff;
      ocount_in = ocount_ff;
      if (tok_take && !do_pop) begin
         ocount_in = ocount_ff + 1'b1;
      end else if (do_pop && !tok_take) begin
         ocount_in = ocount_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_WS1;
         quote_single_ff <= 1'b0;
         error_ff        <= ER_OK;
         kind_ff         <= KIND_BLANK;
         owr_ff          <= '0;
         ord_ff          <= '0;
         ocount_ff       <= '0;
      end else begin
         if (tok_take) begin
            state_ff        <= state_in;
            quote_single_ff <= quote_single_in;
            error_ff        <= error_in;
            kind_ff         <= kind_in;
         end
         owr_ff    <= owr_in;
         ord_ff    <= ord_in;
         ocount_ff <= ocount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_take) begin
         outq[owr_ff] <= res;
      end
   end

endmodule

// ----- src/ini_line_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// ini_line_tokenizer_core
// Character tokenizer for one line of an INI-style file.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive req_opcode/req_char_code and raise push; a beat is
//   taken on a clock edge with push high and full low. Send the bytes of a
//   line, then one beat with req_opcode = 1 to close it.
//   Result queue: while empty is low the oldest result is on the rsp_ ports;
//   raise pop to take it. Every input beat yields exactly one result beat;
//   the line-end beat carries rsp_line_kind and rsp_line_status.
//   A taken beat is stored in the token queue; its result is then registered
//   in the result buffer. Throughput: one byte per cycle while it has room.
//   A four-deep token queue sits between classifier and parser, and a
//   two-deep result buffer follows the parser. When pop stays low the
//   result buffer fills, the parser halts, and full rises once the token
//   queue fills; no beat is lost.
//   Reset (synchronous, active high) empties both queues and returns the
//   parser to the start of a line.
// ----------------------------------------------------------------------------
module ini_line_tokenizer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic       req_opcode,
   input  logic [7:0] req_char_code,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_char_out,
   output logic [2:0] rsp_char_class,
   output logic [1:0] rsp_line_kind,
   output logic [2:0] rsp_line_status,
   output logic       rsp_line_done
);
   import ilt_pkg::*;

   token_type  in_token;
   token_type  head_token;
   logic       head_valid;
   logic       head_take;
   result_type rsp;

   ilt_front u_front (
      .opcode    (req_opcode),
      .char_code (req_char_code),
      .token     (in_token)
   );

   ilt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (push),
      .wr_token  (in_token),
      .full      (full),
      .rd_en     (head_take),
      .rd_token  (head_token),
      .not_empty (head_valid)
   );

   ilt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok       (head_token),
      .tok_valid (head_valid),
      .tok_take  (head_take),
      .rsp       (rsp),
      .empty     (empty),
      .pop       (pop)
   );

   assign rsp_char_out    = rsp.char_out;
   assign rsp_char_class  = rsp.char_class;
   assign rsp_line_kind   = rsp.line_kind;
   assign rsp_line_status = rsp.line_status;
   assign rsp_line_done   = rsp.line_done;

`ifndef SYNTHESIS
   a_done_is_end: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_line_done == (rsp_char_class == CL_END)))
      else $error("line_done and line-end class disagree");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_char_class == CL_DROP || rsp_char_class == CL_END))
         |-> (rsp_char_out == 8'h00))
      else $error("dropped or line-end beat carries a character");

   a_char_no_status: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_line_done)
         |-> (rsp_line_kind == KIND_BLANK && rsp_line_status == ER_OK))
      else $error("character beat carries line kind or status");

   a_no_take_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (head_take && !pop) |-> !($past(!empty) && $past(!pop) && full && !head_valid))
      else $error("parser took a token without one queued");
`endif

endmodule

// ----- verif/ini_line_tokenizer_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ini_line_tokenizer_core_test
// Self-checking bench for the INI line tokenizer core. A short table of
// hand-picked lines runs first, then random lines, mostly well-formed key,
// section and comment lines, with some noise and broken lines mixed in. Every
// beat is predicted by a behavioral copy of the line parser, unless a table
// row gives its own result, and each result beat is compared field by field.
// Four phases: none idle, then sender, receiver, both idle at random.
// ----------------------------------------------------------------------------
module ini_line_tokenizer_core_test;
   import ilt_pkg::*;

   localparam int ITEM_TARGET = 1100;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic       op;
      logic [7:0] code;
      bit         typed;
      result_type res;
   } drill_row_type;

   logic       clock;
   logic       reset         = 1'b1;
   logic       push          = 1'b0;
   logic       req_opcode    = OP_CHAR;
   logic [7:0] req_char_code = 8'h00;
   logic       pop           = 1'b0;
   logic       full;
   logic       empty;
   logic [7:0] rsp_char_out;
   logic [2:0] rsp_char_class;
   logic [1:0] rsp_line_kind;
   logic [2:0] rsp_line_status;
   logic       rsp_line_done;

   // parser copy
   state_type  line_state      = ST_WS1;
   logic       quote_is_single = 1'b0;
   logic [2:0] first_error     = ER_OK;
   logic [1:0] line_kind_now   = KIND_BLANK;

   result_type     expected_tokens[$];
   drill_row_type  drill_rows[$];
   logic [7:0]     line_bytes[$];
   int unsigned beats_sent    = 0;
   int unsigned mismatches    = 0;
   int unsigned push_idle_pct = 0;
   int unsigned pop_stall_pct = 0;
   int unsigned quiet_cycles  = 0;

   ini_line_tokenizer_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_opcode      (req_opcode),
      .req_char_code   (req_char_code),
      .empty           (empty),
      .pop             (pop),
      .rsp_char_out    (rsp_char_out),
      .rsp_char_class  (rsp_char_class),
      .rsp_line_kind   (rsp_line_kind),
      .rsp_line_status (rsp_line_status),
      .rsp_line_done   (rsp_line_done)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic void append_byte(logic [7:0] b);
      line_bytes.insert(line_bytes.size(), b);
   endfunction

   function automatic void add_row(logic op, logic [7:0] code, bit typed, result_type res);
      drill_row_type row;
      row.op    = op;
      row.code  = code;
      row.typed = typed;
      row.res   = res;
      drill_rows.insert(drill_rows.size(), row);
   endfunction

   function automatic bit is_space(logic [7:0] c);
      return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic bit is_name_char(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
             (c >= "a" && c <= "z") || c == CH_UNDER;
   endfunction

   function automatic void enter_error(logic [2:0] code);
      if (first_error == ER_OK) begin
         first_error = code;
      end
      line_state = ST_INVALID;
   endfunction

   function automatic result_type tokenize_byte(logic op, logic [7:0] c);
      result_type r;
      logic [2:0] status;
      logic [2:0] cls;
      logic [7:0] ch;
      logic [7:0] closing;
      r = '0;
      if (op == OP_EOL) begin
         status = first_error;
         if (status == ER_OK) begin
            case (line_state)
               ST_NAME, ST_WS2:          status = ER_MISSING;
               ST_QUOTE, ST_QESC:        status = ER_QUOTING;
               ST_WS6, ST_SECT, ST_WS7:  status = ER_SYNTAX;
               default:                  status = ER_OK;
            endcase
         end
         r.char_class    = CL_END;
         r.line_kind     = line_kind_now;
         r.line_status   = status;
         r.line_done     = 1'b1;
         line_state      = ST_WS1;
         quote_is_single = 1'b0;
         first_error     = ER_OK;
         line_kind_now   = KIND_BLANK;
         return r;
      end
      cls = CL_DROP;
      ch  = c;
      case (line_state)
         ST_WS1: begin
            if (is_space(c)) begin
            end else if (c == CH_LBRACK) begin
               line_state = ST_WS6;
            end else if (is_name_char(c)) begin
               cls = CL_NAME;
               line_kind_now = KIND_KEY;
               line_state = ST_NAME;
            end else if (c == CH_HASH) begin
               line_state = ST_COMMENT;
            end else begin
               enter_error(ER_NAME);
            end
         end
         ST_NAME: begin
            if (is_name_char(c)) cls = CL_NAME;
            else if (is_space(c)) line_state = ST_WS2;
            else if (c == CH_EQ) line_state = ST_WS3;
            else enter_error(ER_NAME);
         end
         ST_WS2: begin
            if (is_space(c)) begin
            end else if (c == CH_EQ) begin
               line_state = ST_WS3;
            end else begin
               enter_error(ER_NAME);
            end
         end
         ST_WS3: begin
            if (is_space(c)) begin
            end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
               quote_is_single = (c == CH_SQUOTE);
               line_state = ST_QUOTE;
            end else begin
               cls = CL_VALUE;
               line_state = ST_VALUE;
            end
         end
         ST_VALUE: begin
            if (is_space(c)) begin
               cls = CL_TENT;
               line_state = ST_WS4;
            end else begin
               cls = CL_VALUE;
            end
         end
         ST_WS4: begin
            if (is_space(c)) begin
               cls = CL_TENT;
            end else if (c == CH_HASH) begin
               line_state = ST_COMMENT;
            end else begin
               cls = CL_VALUE;
               line_state = ST_VALUE;
            end
         end
         ST_QUOTE: begin
            closing = quote_is_single ? CH_SQUOTE : CH_DQUOTE;
            if (c == closing) line_state = ST_WS5;
            else if (c == CH_BSLASH) line_state = ST_QESC;
            else cls = CL_VALUE;
         end
         ST_QESC: begin
            if (c == CH_LC_T) ch = CH_TAB;
            else if (c == CH_LC_R) ch = CH_CR;
            else if (c == CH_LC_N) ch = CH_LF;
            cls = CL_VALUE;
            line_state = ST_QUOTE;
         end
         ST_WS5: begin
            if (is_space(c)) begin
            end else if (c == CH_HASH) begin
               line_state = ST_COMMENT;
            end else begin
               enter_error(ER_SYNTAX);
            end
         end
         ST_WS6: begin
            if (is_space(c)) begin
            end else if (is_name_char(c)) begin
               cls = CL_SECT;
               line_kind_now = KIND_SECTION;
               line_state = ST_SECT;
            end else begin
               enter_error(ER_SECTION);
            end
         end
         ST_SECT: begin
            if (is_name_char(c) || c == CH_DOT) cls = CL_SECT;
            else if (c == CH_RBRACK) line_state = ST_WS5;
            else if (is_space(c)) line_state = ST_WS7;
            else enter_error(ER_SECTION);
         end
         ST_WS7: begin
            if (is_space(c)) begin
            end else if (c == CH_RBRACK) begin
               line_state = ST_WS5;
            end else begin
               enter_error(ER_SECTION);
            end
         end
         ST_COMMENT: cls = CL_COMMENT;
         default:    line_state = ST_INVALID;
      endcase
      r.char_out   = (cls == CL_DROP) ? 8'h00 : ch;
      r.char_class = cls;
      return r;
   endfunction

   // random line content
   function automatic logic [7:0] pick_space();
      int unsigned r;
      r = $urandom_range(0, 7);
      return (r < 5) ? 8'(9 + r) : CH_SPACE;
   endfunction

   function automatic logic [7:0] pick_name_char();
      int unsigned r;
      r = $urandom_range(0, 62);
      if (r < 10) return 8'("0" + r);
      if (r < 36) return 8'("A" + r - 10);
      if (r < 62) return 8'("a" + r - 36);
      return CH_UNDER;
   endfunction

   function automatic logic [7:0] pick_text_char();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(128, 255));
      return 8'($urandom_range(33, 126));
   endfunction

   function automatic void add_spaces(int unsigned maxn);
      repeat ($urandom_range(0, maxn)) append_byte(pick_space());
   endfunction

   function automatic void add_name(bit dotted);
      int unsigned n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         if (dotted && i > 0 && $urandom_range(0, 4) == 0) append_byte(CH_DOT);
         else append_byte(pick_name_char());
      end
   endfunction

   function automatic void add_value();
      logic [7:0] q;
      logic [7:0] c;
      int unsigned r;
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 3) == 0) append_byte(pick_space());
            else append_byte(pick_text_char());
         end
      end else begin
         q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
         append_byte(q);
         repeat ($urandom_range(0, 5)) begin
            r = $urandom_range(0, 5);
            if (r == 0) begin
               append_byte(CH_BSLASH);
               case ($urandom_range(0, 3))
                  0:       append_byte(CH_LC_T);
                  1:       append_byte(CH_LC_R);
                  2:       append_byte(CH_LC_N);
                  default: append_byte(8'($urandom_range(0, 255)));
               endcase
            end else begin
               c = (r == 1) ? pick_space() : pick_text_char();
               append_byte((c == q || c == CH_BSLASH) ? 8'("a") : c);
            end
         end
         if ($urandom_range(0, 9) != 0) append_byte(q);
      end
   endfunction

   function automatic void add_comment_tail();
      if ($urandom_range(0, 2) == 0) begin
         append_byte(CH_HASH);
         repeat ($urandom_range(0, 4)) append_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   function automatic void build_key_line();
      add_spaces(2);
      add_name(1'b0);
      add_spaces(1);
      append_byte(CH_EQ);
      add_spaces(1);
      add_value();
      add_spaces(2);
      add_comment_tail();
   endfunction

   function automatic void build_section_line();
      add_spaces(1);
      append_byte(CH_LBRACK);
      add_spaces(1);
      add_name(1'b1);
      add_spaces(1);
      append_byte(CH_RBRACK);
      add_spaces(1);
      add_comment_tail();
   endfunction

   task automatic send_beat(logic op, logic [7:0] code, bit typed, result_type typed_res);
      result_type predicted;
      while ($urandom_range(0, 99) < push_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push          <= 1'b1;
      req_opcode    <= op;
      req_char_code <= code;
      @(posedge clock);
      while (full) @(posedge clock);
      predicted = tokenize_byte(op, code);
      expected_tokens.insert(expected_tokens.size(), typed ? typed_res : predicted);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_line();
      int unsigned pick;
      int unsigned keep;
      line_bytes.delete();
      pick = $urandom_range(0, 19);
      if (pick <= 8) begin
         build_key_line();
      end else if (pick <= 12) begin
         build_section_line();
      end else if (pick <= 14) begin
         add_spaces(2);
         append_byte(CH_HASH);
         repeat ($urandom_range(0, 6)) append_byte(8'($urandom_range(0, 255)));
      end else if (pick == 15) begin
         add_spaces(3);
      end else if (pick <= 17) begin
         repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(0, 255)));
      end else begin
         // truncated, and sometimes corrupted, well-formed line
         if ($urandom_range(0, 1)) build_key_line();
         else build_section_line();
         keep = $urandom_range(0, line_bytes.size() - 1);
         while (line_bytes.size() > keep) void'(line_bytes.pop_back());
         if (line_bytes.size() > 0 && $urandom_range(0, 1)) begin
            line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         end
      end
      foreach (line_bytes[i]) send_beat(OP_CHAR, line_bytes[i], 1'b0, '0);
      send_beat(OP_EOL, 8'($urandom_range(0, 255)), 1'b0, '0);
   endtask

   task automatic check_field(string fname, logic [7:0] want, logic [7:0] seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, seen);
         mismatches++;
      end
   endtask

   always @(negedge clock) begin
      pop <= ($urandom_range(0, 99) >= pop_stall_pct);
   end

   always @(posedge clock) begin : result_check
      result_type want;
      result_type got;
      if (!reset && pop && !empty) begin
         got = '{rsp_char_out, rsp_char_class, rsp_line_kind, rsp_line_status, rsp_line_done};
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h", $time, got);
            mismatches++;
         end else begin
            want = expected_tokens.pop_front();
            check_field("char_out", want.char_out, got.char_out);
            check_field("char_class", 8'(want.char_class), 8'(got.char_class));
            check_field("line_kind", 8'(want.line_kind), 8'(got.line_kind));
            check_field("line_status", 8'(want.line_status), 8'(got.line_status));
            check_field("line_done", 8'(want.line_done), 8'(got.line_done));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned push_pct_of[4];
      int unsigned pop_pct_of[4];
      push_pct_of = '{0, 60, 0, 34};
      pop_pct_of  = '{0, 0, 60, 34};

      // line end right after reset, byte extremes, error, key name
      add_row(OP_EOL, 8'hFF, 1'b1, '{8'h00, CL_END, KIND_BLANK, ER_OK, 1'b1});
      add_row(OP_CHAR, 8'h00, 1'b1, '{8'h00, CL_DROP, KIND_BLANK, ER_OK, 1'b0});
      add_row(OP_CHAR, 8'hFF, 1'b1, '{8'h00, CL_DROP, KIND_BLANK, ER_OK, 1'b0});
      add_row(OP_EOL, 8'h00, 1'b1, '{8'h00, CL_END, KIND_BLANK, ER_NAME, 1'b1});
      add_row(OP_CHAR, "k", 1'b1, '{"k", CL_NAME, KIND_BLANK, ER_OK, 1'b0});
      // bare backslash value, tentative spaces, trailing comment, missing value
      add_row(OP_CHAR, CH_EQ, 1'b0, '0);
      add_row(OP_CHAR, CH_BSLASH, 1'b0, '0);
      add_row(OP_CHAR, CH_SPACE, 1'b0, '0);
      add_row(OP_CHAR, "b", 1'b0, '0);
      add_row(OP_CHAR, CH_TAB, 1'b0, '0);
      add_row(OP_CHAR, CH_HASH, 1'b0, '0);
      add_row(OP_CHAR, "c", 1'b0, '0);
      add_row(OP_EOL, 8'h5A, 1'b0, '0);
      add_row(OP_CHAR, "x", 1'b0, '0);
      add_row(OP_EOL, 8'h01, 1'b1, '{8'h00, CL_END, KIND_KEY, ER_MISSING, 1'b1});
      // single-quoted value, known and unknown escapes, unclosed quote
      add_row(OP_CHAR, "x", 1'b0, '0);
      add_row(OP_CHAR, CH_EQ, 1'b0, '0);
      add_row(OP_CHAR, CH_SQUOTE, 1'b0, '0);
      add_row(OP_CHAR, CH_BSLASH, 1'b0, '0);
      add_row(OP_CHAR, CH_LC_N, 1'b0, '0);
      add_row(OP_CHAR, CH_BSLASH, 1'b0, '0);
      add_row(OP_CHAR, "q", 1'b0, '0);
      add_row(OP_EOL, 8'h80, 1'b1, '{8'h00, CL_END, KIND_KEY, ER_QUOTING, 1'b1});
      // unfinished section header
      add_row(OP_CHAR, CH_LBRACK, 1'b0, '0);
      add_row(OP_CHAR, "s", 1'b0, '0);
      add_row(OP_EOL, 8'h7F, 1'b1, '{8'h00, CL_END, KIND_SECTION, ER_SYNTAX, 1'b1});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 4; p++) begin
         push_idle_pct = push_pct_of[p];
         pop_stall_pct = pop_pct_of[p];
         if (p == 0) begin
            foreach (drill_rows[i]) begin
               send_beat(drill_rows[i].op, drill_rows[i].code, drill_rows[i].typed,
                         drill_rows[i].res);
            end
         end
         while (beats_sent < (p + 1) * ITEM_TARGET / 4) send_random_line();
      end
      push <= 1'b0;

      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- ini_line_tokenizer_core.f -----
src/ilt_pkg.sv
src/ilt_front.sv
src/ilt_queue.sv
src/ilt_back.sv
src/ini_line_tokenizer_core.sv
verif/ini_line_tokenizer_core_test.sv
